// ----- src/kf2_pkg.sv -----
// ----------------------------------------------------------------------------
// kf2_pkg: shared types and defaults for the two-state Kalman filter
// Sequencer states, register indexes and noise and covariance reset values.
// ----------------------------------------------------------------------------
package kf2_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // register indexes on the config channel
    localparam logic [2:0] REG_Q_POS  = 3'd0;
    localparam logic [2:0] REG_Q_RATE = 3'd1;
    localparam logic [2:0] REG_R_MEAS = 3'd2;
    localparam logic [2:0] REG_P_INIT = 3'd3;

    // reset values, fixed point
    localparam logic [63:0] RST_Q_POS  = 64'd66;
    localparam logic [63:0] RST_Q_RATE = 64'd32768;
    localparam logic [63:0] RST_R_MEAS = 64'd655360;
    localparam logic [63:0] RST_P_INIT = 64'd655360;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED_A,
        ST_PRED_B,
        ST_PRED_C,
        ST_PRED_D,
        ST_UPD_A,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_MUL,
        ST_MUL_END,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

// ----- src/kalman_filter_two_state.sv -----
// ----------------------------------------------------------------------------
// kalman_filter_two_state: constant-velocity Kalman filter, one state pair
// Predict, gain, correct and covariance update in saturating fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one measurement beat plus a
//   start flag; start reloads position from the measurement, rate to zero,
//   and the covariance diagonal from the initial covariance register.
//   Output channel (o_valid / i_ready) returns one beat per input beat:
//   filtered position, rate estimate and a flag set when any operation of
//   that step clipped at the word bounds.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the four noise and
//   covariance registers by index; it is always ready. Write only when idle.
// Datapath (values signed fixed point, Q16.16 with the default parameters):
//   Two gain divisions run in parallel as restoring dividers, one quotient
//   bit per cycle; then six products run in parallel as bit-serial
//   shift-add lanes, one multiplier bit per cycle. One item is in flight
//   at a time; the next beat is taken once the result has been registered.
// Reset: synchronous, active low. Clears estimates and covariance to zero,
//   loads register defaults, drops o_valid.
// Stall: the result sits in an output register; the next item is accepted
//   and processed, and only waits at its own end if the old beat is unsent.
// ----------------------------------------------------------------------------
module kalman_filter_two_state #(
    parameter int FRAC_BITS   = kf2_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = kf2_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // measurement beats
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_measurement,
    input  logic                          i_start_new,
    // result beats
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [VALUE_WIDTH-1:0] o_filtered_position,
    output logic signed [VALUE_WIDTH-1:0] o_rate_estimate,
    output logic                          o_saturated,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [VALUE_WIDTH-2:0]        i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;                       // dividend / quotient bits
    localparam int QW = (NW > 2 * W) ? NW : 2 * W;   // widest raw magnitude
    localparam int CW = $clog2(NW + 1);

    typedef struct packed {
        logic         c;
        logic [W-1:0] v;
    } t_sat;

    // ---- saturating helpers ----
    function automatic t_sat sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        t_sat       r;
        s = {a[W-1], a} + {b[W-1], b};
        r.c = (s[W] != s[W-1]);
        if (r.c) r.v = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else     r.v = s[W-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        t_sat       r;
        s = {a[W-1], a} - {b[W-1], b};
        r.c = (s[W] != s[W-1]);
        if (r.c) r.v = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else     r.v = s[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    // clip a magnitude with sign into the signed word range
    function automatic t_sat pack(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] lim;
        t_sat          r;
        lim = neg ? QW'({1'b1, {(W-1){1'b0}}}) : QW'({1'b0, {(W-1){1'b1}}});
        r.c = (q > lim);
        if (r.c)      r.v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (neg) r.v = ~q[W-1:0] + 1'b1;
        else          r.v = q[W-1:0];
        return r;
    endfunction

    // ---- registers ----
    kf2_pkg::t_state r_state, n_state;

    logic [W-2:0] r_q_pos, r_q_rate, r_r_meas, r_p_init;

    logic [W-1:0] r_pos, r_rate, r_p11, r_p12, r_p21, r_p22;
    logic [W-1:0] r_z, r_t, r_den, r_res;
    logic         r_clip;

    // division lanes: 0 -> gain on position, 1 -> gain on rate
    logic [NW-1:0] r_num [2];
    logic [NW-1:0] r_quo [2];
    logic [W:0]    r_rem [2];
    logic          r_dneg [2];

    // multiply lanes: 0..2 use k1, 3..5 use k2
    logic [W-1:0]   r_ks1, r_ks2;
    logic [W-1:0]   r_mc  [6];
    logic [2*W-1:0] r_acc [6];
    logic           r_mneg [6];
    logic [W-1:0]   r_mv  [6];

    logic [CW-1:0] r_cnt;

    logic         r_o_valid;
    logic [W-1:0] r_o_pos, r_o_rate;
    logic         r_o_sat;

    logic w_in_acc, w_out_free, w_div_last, w_mul_last;

    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_div_last = (r_cnt == CW'(NW - 1));
    assign w_mul_last = (r_cnt == CW'(W - 1));

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            kf2_pkg::ST_IDLE:     if (w_in_acc) n_state = kf2_pkg::ST_PRED_A;
            kf2_pkg::ST_PRED_A:   n_state = kf2_pkg::ST_PRED_B;
            kf2_pkg::ST_PRED_B:   n_state = kf2_pkg::ST_PRED_C;
            kf2_pkg::ST_PRED_C:   n_state = kf2_pkg::ST_PRED_D;
            kf2_pkg::ST_PRED_D:   n_state = kf2_pkg::ST_UPD_A;
            kf2_pkg::ST_UPD_A:    n_state = kf2_pkg::ST_DIV_LOAD;
            kf2_pkg::ST_DIV_LOAD: n_state = kf2_pkg::ST_DIV;
            kf2_pkg::ST_DIV:      if (w_div_last) n_state = kf2_pkg::ST_DIV_END;
            kf2_pkg::ST_DIV_END:  n_state = kf2_pkg::ST_MUL;
            kf2_pkg::ST_MUL:      if (w_mul_last) n_state = kf2_pkg::ST_MUL_END;
            kf2_pkg::ST_MUL_END:  n_state = kf2_pkg::ST_FIN;
            kf2_pkg::ST_FIN:      n_state = kf2_pkg::ST_OUT;
            kf2_pkg::ST_OUT:      if (w_out_free) n_state = kf2_pkg::ST_IDLE;
            default:              n_state = kf2_pkg::ST_IDLE;
        endcase
    end

    // ---- handshake outputs ----
    always_comb begin
        o_ready     = (r_state == kf2_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    assign o_valid             = r_o_valid;
    assign o_filtered_position = r_o_pos;
    assign o_rate_estimate     = r_o_rate;
    assign o_saturated         = r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kf2_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // ---- config registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pos  <= (W-1)'(kf2_pkg::RST_Q_POS);
            r_q_rate <= (W-1)'(kf2_pkg::RST_Q_RATE);
            r_r_meas <= (W-1)'(kf2_pkg::RST_R_MEAS);
            r_p_init <= (W-1)'(kf2_pkg::RST_P_INIT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kf2_pkg::REG_Q_POS:  r_q_pos  <= i_cfg_data;
                kf2_pkg::REG_Q_RATE: r_q_rate <= i_cfg_data;
                kf2_pkg::REG_R_MEAS: r_r_meas <= i_cfg_data;
                kf2_pkg::REG_P_INIT: r_p_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == kf2_pkg::ST_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kf2_pkg::ST_OUT && w_out_free) begin
            r_o_pos  <= r_pos;
            r_o_rate <= r_rate;
            r_o_sat  <= r_clip;
        end
    end

    // ---- filter state and datapath ----
    t_sat w_a0, w_a1, w_a2, w_a3;
    t_sat w_pk [6];
    t_sat w_dk0, w_dk1;
    logic w_den_nz;

    assign w_den_nz = (r_den != '0);
    assign w_dk0    = pack(QW'(r_quo[0]), r_dneg[0]);
    assign w_dk1    = pack(QW'(r_quo[1]), r_dneg[1]);

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_pk[j] = pack(QW'(r_acc[j] >> F), r_mneg[j]);
        end
    end

    always_comb begin
        w_a0 = '0;
        w_a1 = '0;
        w_a2 = '0;
        w_a3 = '0;
        case (r_state)
            kf2_pkg::ST_PRED_A: begin
                w_a0 = sat_add(r_pos, r_rate);
                w_a1 = sat_add(r_p12, r_p12);
            end
            kf2_pkg::ST_PRED_B: w_a0 = sat_add(r_p11, r_t);
            kf2_pkg::ST_PRED_C: w_a0 = sat_add(r_t, r_p22);
            kf2_pkg::ST_PRED_D: begin
                w_a0 = sat_add(r_t, {1'b0, r_q_pos});
                w_a1 = sat_add(r_p12, r_p22);
                w_a2 = sat_add(r_p21, r_p22);
                w_a3 = sat_add(r_p22, {1'b0, r_q_rate});
            end
            kf2_pkg::ST_UPD_A: begin
                w_a0 = sat_add(r_p11, {1'b0, r_r_meas});
                w_a1 = sat_sub(r_z, r_pos);
            end
            kf2_pkg::ST_FIN: begin
                w_a0 = sat_add(r_pos, r_mv[0]);
                w_a1 = sat_add(r_rate, r_mv[3]);
                w_a2 = sat_sub(r_p11, r_mv[1]);
                w_a3 = sat_sub(r_p12, r_mv[2]);
            end
            default: ;
        endcase
    end

    t_sat w_f4, w_f5;
    assign w_f4 = sat_sub(r_p21, r_mv[4]);
    assign w_f5 = sat_sub(r_p22, r_mv[5]);

    logic [W:0] w_rs [2];
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_rs[j] = {r_rem[j][W-1:0], r_num[j][NW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_rate <= '0;
            r_p11  <= '0;
            r_p12  <= '0;
            r_p21  <= '0;
            r_p22  <= '0;
            r_clip <= 1'b0;
            r_cnt  <= '0;
        end else begin
            case (r_state)
                kf2_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_z    <= i_measurement;
                        r_clip <= 1'b0;
                        if (i_start_new) begin
                            r_pos  <= i_measurement;
                            r_rate <= '0;
                            r_p11  <= {1'b0, r_p_init};
                            r_p12  <= '0;
                            r_p21  <= '0;
                            r_p22  <= {1'b0, r_p_init};
                        end
                    end
                end
                kf2_pkg::ST_PRED_A: begin
                    r_pos  <= w_a0.v;
                    r_t    <= w_a1.v;
                    r_clip <= r_clip | w_a0.c | w_a1.c;
                end
                kf2_pkg::ST_PRED_B, kf2_pkg::ST_PRED_C: begin
                    r_t    <= w_a0.v;
                    r_clip <= r_clip | w_a0.c;
                end
                kf2_pkg::ST_PRED_D: begin
                    r_p11  <= w_a0.v;
                    r_p12  <= w_a1.v;
                    r_p21  <= w_a2.v;
                    r_p22  <= w_a3.v;
                    r_clip <= r_clip | w_a0.c | w_a1.c | w_a2.c | w_a3.c;
                end
                kf2_pkg::ST_UPD_A: begin
                    r_den  <= w_a0.v;
                    r_res  <= w_a1.v;
                    r_clip <= r_clip | w_a0.c | w_a1.c;
                end
                kf2_pkg::ST_DIV_LOAD: begin
                    // dividend is |a| << F, shifted in MSB first
                    r_num[0]  <= {mag(r_p11), {F{1'b0}}};
                    r_num[1]  <= {mag(r_p21), {F{1'b0}}};
                    r_dneg[0] <= r_p11[W-1] ^ r_den[W-1];
                    r_dneg[1] <= r_p21[W-1] ^ r_den[W-1];
                    for (int j = 0; j < 2; j++) begin
                        r_rem[j] <= '0;
                        r_quo[j] <= '0;
                    end
                    r_cnt <= '0;
                end
                kf2_pkg::ST_DIV: begin
                    for (int j = 0; j < 2; j++) begin
                        r_num[j] <= r_num[j] << 1;
                        if (w_rs[j] >= {1'b0, mag(r_den)}) begin
                            r_rem[j] <= w_rs[j] - {1'b0, mag(r_den)};
                            r_quo[j] <= {r_quo[j][NW-2:0], 1'b1};
                        end else begin
                            r_rem[j] <= w_rs[j];
                            r_quo[j] <= {r_quo[j][NW-2:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                kf2_pkg::ST_DIV_END: begin
                    // zero divisor: no correction, no clip
                    r_clip <= r_clip | (w_den_nz & (w_dk0.c | w_dk1.c));
                    r_ks1  <= w_den_nz ? mag(w_dk0.v) : '0;
                    r_ks2  <= w_den_nz ? mag(w_dk1.v) : '0;
                    r_mc[0] <= mag(r_res);
                    r_mc[1] <= mag(r_p11);
                    r_mc[2] <= mag(r_p12);
                    r_mc[3] <= mag(r_res);
                    r_mc[4] <= mag(r_p11);
                    r_mc[5] <= mag(r_p12);
                    for (int j = 0; j < 6; j++) begin
                        r_acc[j] <= '0;
                    end
                    r_cnt <= '0;
                end
                kf2_pkg::ST_MUL: begin
                    for (int j = 0; j < 6; j++) begin
                        if ((j < 3) ? r_ks1[W-1] : r_ks2[W-1])
                            r_acc[j] <= (r_acc[j] << 1) + (2*W)'(r_mc[j]);
                        else
                            r_acc[j] <= r_acc[j] << 1;
                    end
                    r_ks1 <= r_ks1 << 1;
                    r_ks2 <= r_ks2 << 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                kf2_pkg::ST_MUL_END: begin
                    for (int j = 0; j < 6; j++) begin
                        r_mv[j] <= w_pk[j].v;
                    end
                    r_clip <= r_clip | w_pk[0].c | w_pk[1].c | w_pk[2].c
                                     | w_pk[3].c | w_pk[4].c | w_pk[5].c;
                end
                kf2_pkg::ST_FIN: begin
                    r_pos  <= w_a0.v;
                    r_rate <= w_a1.v;
                    r_p11  <= w_a2.v;
                    r_p12  <= w_a3.v;
                    r_p21  <= w_f4.v;
                    r_p22  <= w_f5.v;
                    r_clip <= r_clip | w_a0.c | w_a1.c | w_a2.c | w_a3.c
                                     | w_f4.c | w_f5.c;
                end
                default: ;
            endcase
        end
    end

    // product signs, fixed once the gains are known
    always_ff @(posedge i_clk) begin
        if (r_state == kf2_pkg::ST_DIV_END) begin
            r_mneg[0] <= (w_den_nz & w_dk0.v[W-1]) ^ r_res[W-1];
            r_mneg[1] <= (w_den_nz & w_dk0.v[W-1]) ^ r_p11[W-1];
            r_mneg[2] <= (w_den_nz & w_dk0.v[W-1]) ^ r_p12[W-1];
            r_mneg[3] <= (w_den_nz & w_dk1.v[W-1]) ^ r_res[W-1];
            r_mneg[4] <= (w_den_nz & w_dk1.v[W-1]) ^ r_p11[W-1];
            r_mneg[5] <= (w_den_nz & w_dk1.v[W-1]) ^ r_p12[W-1];
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kalman_filter_two_state
// Drives measurement beats and register writes, predicts every result beat
// with a saturating fixed-point filter model and compares each field.
// ----------------------------------------------------------------------------

class kf_scoreboard;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    longint q_pos, q_rate, r_meas, p_init;
    longint pos, rate, p11, p12, p21, p22;
    bit     clipped;
    int     mismatches;
    logic [64:0] expected_beats[$];   // {position, rate, saturated}

    function new();
        q_pos = 66; q_rate = 32768; r_meas = 655360; p_init = 655360;
        pos = 0; rate = 0; p11 = 0; p12 = 0; p21 = 0; p22 = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [30:0] data);
        case (idx)
            kf2_pkg::REG_Q_POS:  q_pos  = longint'(data);
            kf2_pkg::REG_Q_RATE: q_rate = longint'(data);
            kf2_pkg::REG_R_MEAS: r_meas = longint'(data);
            kf2_pkg::REG_P_INIT: p_init = longint'(data);
            default: ;
        endcase
    endfunction

    function longint clamp(longint v);
        if (v > WMAX) begin
            clipped = 1;
            return WMAX;
        end
        if (v < WMIN) begin
            clipped = 1;
            return WMIN;
        end
        return v;
    endfunction

    function longint sat_add(longint a, longint b);
        return clamp(a + b);
    endfunction

    function longint sat_sub(longint a, longint b);
        return clamp(a - b);
    endfunction

    // magnitude result with sign, clipped to the word range
    function longint pack(longint unsigned m, bit neg);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) begin
            clipped = 1;
            return neg ? WMIN : WMAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint sat_mul(longint a, longint b);
        longint unsigned ua, ub;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        return pack((ua * ub) >> 16, (a < 0) != (b < 0));
    endfunction

    function longint sat_div(longint a, longint b);
        longint unsigned ua, ub;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        return pack((ua << 16) / ub, (a < 0) != (b < 0));
    endfunction

    // one filter step per accepted measurement beat
    function void note_input(logic signed [31:0] meas, logic start);
        longint z, denom, k1, k2, res, n11, n12, n21, n22;
        z = longint'(meas);
        clipped = 0;
        if (start) begin
            pos = z; rate = 0; p11 = p_init; p12 = 0; p21 = 0; p22 = p_init;
        end
        // predict
        pos = sat_add(pos, rate);
        p11 = sat_add(sat_add(sat_add(p11, sat_add(p12, p12)), p22), q_pos);
        p12 = sat_add(p12, p22);
        p21 = sat_add(p21, p22);
        p22 = sat_add(p22, q_rate);
        // update
        denom = sat_add(p11, r_meas);
        if (denom != 0) begin
            k1 = sat_div(p11, denom);
            k2 = sat_div(p21, denom);
        end else begin
            k1 = 0;
            k2 = 0;
        end
        res  = sat_sub(z, pos);
        pos  = sat_add(pos, sat_mul(k1, res));
        rate = sat_add(rate, sat_mul(k2, res));
        n11 = sat_sub(p11, sat_mul(k1, p11));
        n12 = sat_sub(p12, sat_mul(k1, p12));
        n21 = sat_sub(p21, sat_mul(k2, p11));
        n22 = sat_sub(p22, sat_mul(k2, p12));
        p11 = n11; p12 = n12; p21 = n21; p22 = n22;
        expected_beats.insert(expected_beats.size(), {pos[31:0], rate[31:0], clipped});
    endfunction

    function void check_result(logic [31:0] fpos, logic [31:0] frate, logic fsat);
        logic [64:0] exp_beat;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat pos=%h rate=%h sat=%b", fpos, frate, fsat);
            return;
        end
        exp_beat = expected_beats.pop_front();
        if (exp_beat !== {fpos, frate, fsat}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp pos=%h rate=%h sat=%b, got pos=%h rate=%h sat=%b",
                         exp_beat[64:33], exp_beat[32:1], exp_beat[0], fpos, frate, fsat);
        end
    endfunction
endclass

module testbench;
    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [31:0] i_measurement = 0;
    logic               i_start_new = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic signed [31:0] o_filtered_position;
    logic signed [31:0] o_rate_estimate;
    logic               o_saturated;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = 0;
    logic [30:0]        i_cfg_data = 0;

    kf_scoreboard filter_sb = new();
    int          send_idle_pct = 0;   // chance per cycle the sender holds off
    int          recv_idle_pct = 0;   // chance per cycle the receiver stalls
    logic signed [31:0] walk;         // drifting track for realistic sequences

    kalman_filter_two_state DUT (.*);

    always #6 i_clk = ~i_clk;

    // receiver stall pattern, one update per edge
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    // both monitors sample at the edge, before any nonblocking update lands
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            filter_sb.note_input(i_measurement, i_start_new);
        if (i_rst_n && o_valid && i_ready)
            filter_sb.check_result(o_filtered_position, o_rate_estimate, o_saturated);
    end

    // one measurement beat; valid stays up when the next beat follows at once
    task automatic send_meas(logic signed [31:0] meas, logic start);
        i_valid       <= 1;
        i_measurement <= meas;
        i_start_new   <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        filter_sb.set_reg(idx, data);
    endtask

    // drain: wait until all beats are back, then let the bench sit idle
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (filter_sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_all(logic [30:0] qp, logic [30:0] qr, logic [30:0] rm,
                           logic [30:0] pi);
        write_reg(kf2_pkg::REG_Q_POS, qp);
        write_reg(kf2_pkg::REG_Q_RATE, qr);
        write_reg(kf2_pkg::REG_R_MEAS, rm);
        write_reg(kf2_pkg::REG_P_INIT, pi);
    endtask

    // mostly tracked sequences with small steps, some restarts and wild values
    task automatic random_items(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                walk = $urandom;
                send_meas(walk, 1'b1);
            end else if (pick < 12) begin
                send_meas($urandom, 1'($urandom_range(1)));
            end else begin
                walk = walk + $signed($urandom_range(131072)) - 65536;
                send_meas(walk, 1'b0);
            end
        end
    endtask

    initial begin
        walk = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes of the measurement, restarts, reset defaults
        send_meas(32'sh0000_0000, 1'b1);
        send_meas(32'sh0001_0000, 1'b0);
        send_meas(32'sh0002_0000, 1'b0);
        send_meas(32'sh7fff_ffff, 1'b0);
        send_meas(32'sh8000_0000, 1'b0);
        send_meas(32'sh7fff_ffff, 1'b1);
        send_meas(32'sh8000_0000, 1'b0);
        send_meas(32'sh8000_0000, 1'b1);
        send_meas(32'sh7fff_ffff, 1'b0);
        send_meas(32'shffff_ffff, 1'b1);
        drain();
        // largest noise and covariance: clipping all over
        set_all(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        send_meas(32'sh7fff_ffff, 1'b1);
        send_meas(32'sh8000_0000, 1'b0);
        send_meas(32'sh0000_0000, 1'b0);
        send_meas(32'sh1234_5678, 1'b1);
        drain();
        // smallest legal values: no noise, one-LSB measurement noise
        set_all(31'd0, 31'd0, 31'd1, 31'd0);
        send_meas(32'sh0005_0000, 1'b1);
        send_meas(32'sh0006_0000, 1'b0);
        send_meas(32'sh8000_0000, 1'b0);
        send_meas(32'sh7fff_ffff, 1'b0);
        drain();

        // random phases: receiver-heavy idle, sender-heavy, then no idling
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 24; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: set_all(31'd66, 31'd32768, 31'd655360, 31'd655360);
                3: set_all(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
                4: set_all(31'd0, 31'd0, 31'd1, 31'd0);
                default: set_all(31'($urandom_range(200000)), 31'($urandom_range(200000)),
                                 31'($urandom_range(2000000, 1)),
                                 31'($urandom_range(2000000)));
            endcase
            random_items(140);
            drain();
        end

        if (filter_sb.mismatches == 0 && filter_sb.expected_beats.size() == 0)
            $display("PASS kalman_filter_two_state");
        else
            $display("FAIL kalman_filter_two_state");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL kalman_filter_two_state");
        $finish;
    end
endmodule

// ----- files.f -----
src/kf2_pkg.sv
src/kalman_filter_two_state.sv
tb/testbench.sv
